FILE: design/cts_pkg.sv
package cts_pkg;

    // Default parameter values.
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_CELLS_DEF = 1048576;

    // Register reset values.
    localparam logic [19:0] CFL_RESET   = 20'd52429;
    localparam logic [20:0] COUNT_RESET = 21'd1;

    // Serial unit lengths.
    localparam int SQRT_STEPS = 32;
    localparam int NUM_W      = 51;
    localparam int DIV_STEPS  = NUM_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);
    localparam int LIMIT_W    = 25;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CFL        = 2'd0;
    localparam logic [1:0] CFG_CELL_COUNT = 2'd1;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_FACE   = 4'd2;
    localparam logic [3:0] OP_M1     = 4'd3;
    localparam logic [3:0] OP_M2     = 4'd4;
    localparam logic [3:0] OP_M3     = 4'd5;
    localparam logic [3:0] OP_M4     = 4'd6;
    localparam logic [3:0] OP_M5     = 4'd7;
    localparam logic [3:0] OP_SQRT   = 4'd8;
    localparam logic [3:0] OP_M6     = 4'd9;
    localparam logic [3:0] OP_M7     = 4'd10;
    localparam logic [3:0] OP_M8     = 4'd11;
    localparam logic [3:0] OP_M9     = 4'd12;
    localparam logic [3:0] OP_DIV    = 4'd13;
    localparam logic [3:0] OP_FINISH = 4'd14;

    typedef struct packed {
        logic signed [31:0] vel_u;
        logic signed [31:0] vel_v;
        logic [30:0]        sound_speed;
        logic signed [31:0] iface_lo_x;
        logic signed [31:0] iface_lo_y;
        logic signed [31:0] iface_hi_x;
        logic signed [31:0] iface_hi_y;
        logic signed [31:0] jface_lo_x;
        logic signed [31:0] jface_lo_y;
        logic signed [31:0] jface_hi_x;
        logic signed [31:0] jface_hi_y;
        logic [30:0]        cell_area;
    } t_cell_in;

    typedef struct packed {
        logic [31:0] min_step;
        logic        bad_step;
        logic [19:0] bad_cell;
    } t_step_out;

    typedef struct packed {
        logic [1:0]  index;
        logic [20:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic [3:0] op;
        logic       face;
    } t_dp_cmd;

    typedef struct packed {
        logic pass_end;
        logic out_busy;
    } t_dp_sts;

endpackage

FILE: design/cts_stream_if.sv
interface cts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/cts_ctrl.sv
module cts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  cts_pkg::t_dp_sts i_sts,
    output cts_pkg::t_dp_cmd o_cmd
);
    import cts_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FACE = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_M4   = 4'd5;
    localparam logic [3:0] ST_M5   = 4'd6;
    localparam logic [3:0] ST_SQRT = 4'd7;
    localparam logic [3:0] ST_M6   = 4'd8;
    localparam logic [3:0] ST_M7   = 4'd9;
    localparam logic [3:0] ST_M8   = 4'd10;
    localparam logic [3:0] ST_M9   = 4'd11;
    localparam logic [3:0] ST_DIV  = 4'd12;
    localparam logic [3:0] ST_DONE = 4'd13;

    logic [3:0]            r_state, n_state;
    logic                  r_face, n_face;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_IDLE);

    // Sequencer: two face passes, each with a serial root, then a serial divide.
    always_comb begin
        n_state    = r_state;
        n_face     = r_face;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NONE;
        o_cmd.face = r_face;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_face   = 1'b0;
                    n_state  = ST_FACE;
                end
            end
            ST_FACE: begin
                o_cmd.op = OP_FACE;
                n_state  = ST_M1;
            end
            ST_M1: begin
                o_cmd.op = OP_M1;
                n_state  = ST_M2;
            end
            ST_M2: begin
                o_cmd.op = OP_M2;
                n_state  = ST_M3;
            end
            ST_M3: begin
                o_cmd.op = OP_M3;
                n_state  = ST_M4;
            end
            ST_M4: begin
                o_cmd.op = OP_M4;
                n_state  = ST_M5;
            end
            ST_M5: begin
                o_cmd.op = OP_M5;
                n_cnt    = '0;
                n_state  = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == STEP_CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_M6;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_M6: begin
                o_cmd.op = OP_M6;
                n_state  = ST_M7;
            end
            ST_M7: begin
                o_cmd.op = OP_M7;
                if (!r_face) begin
                    n_face  = 1'b1;
                    n_state = ST_FACE;
                end else begin
                    n_state = ST_M8;
                end
            end
            ST_M8: begin
                o_cmd.op = OP_M8;
                n_state  = ST_M9;
            end
            ST_M9: begin
                o_cmd.op = OP_M9;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                // Hold while a pass result would land on a result not yet taken.
                if (!(i_sts.pass_end && i_sts.out_busy)) begin
                    o_cmd.op = OP_FINISH;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_face  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_face  <= n_face;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: design/cts_datapath.sv
module cts_datapath #(
    parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF,
    parameter int MAX_CELLS = cts_pkg::MAX_CELLS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cts_pkg::t_dp_cmd   i_cmd,
    output cts_pkg::t_dp_sts   o_sts,
    input  cts_pkg::t_cell_in  i_cell,
    input  logic               i_cfg_valid,
    input  cts_pkg::t_cfg_wr   i_cfg,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cts_pkg::t_step_out o_out
);
    import cts_pkg::*;

    localparam int SR_W   = 64 - FRAC_BITS;
    localparam int DEN_W  = SR_W + 1;
    localparam int REM_W  = 35;

    // Configuration registers.
    logic [19:0] r_cfl;
    logic [20:0] r_cell_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfl        <= CFL_RESET;
            r_cell_count <= COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg.index)
                CFG_CFL:        r_cfl        <= i_cfg.value[19:0];
                CFG_CELL_COUNT: r_cell_count <= i_cfg.value;
                default: ;
            endcase
        end
    end

    // Working registers.
    t_cell_in          r_in;
    logic [31:0]       r_mx, r_my;
    logic              r_nx, r_ny;
    logic [63:0]       r_prod, r_p1, r_dot, r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [31:0]       r_root;
    logic [DEN_W-1:0]  r_den;
    logic              r_zero;
    logic [NUM_W-1:0]  r_num;
    logic              r_numz;
    logic [DEN_W-1:0]  r_drem;

    // Pass state and result register.
    logic [31:0] r_min;
    logic [20:0] r_counter;
    logic        r_err;
    logic [19:0] r_first_bad;
    logic        r_out_valid;
    t_step_out   r_out;

    // Face average of the selected pair: floor((lo + hi) / 2).
    logic [31:0] lo_x, lo_y, hi_x, hi_y;
    logic [32:0] sum_x, sum_y;
    logic [31:0] sx, sy, mag_x, mag_y, mag_u, mag_v;

    always_comb begin
        if (i_cmd.face) begin
            lo_x = r_in.jface_lo_x;
            lo_y = r_in.jface_lo_y;
            hi_x = r_in.jface_hi_x;
            hi_y = r_in.jface_hi_y;
        end else begin
            lo_x = r_in.iface_lo_x;
            lo_y = r_in.iface_lo_y;
            hi_x = r_in.iface_hi_x;
            hi_y = r_in.iface_hi_y;
        end
        sum_x = {lo_x[31], lo_x} + {hi_x[31], hi_x};
        sum_y = {lo_y[31], lo_y} + {hi_y[31], hi_y};
        sx    = sum_x[32:1];
        sy    = sum_y[32:1];
        mag_x = sx[31] ? (~sx + 32'd1) : sx;
        mag_y = sy[31] ? (~sy + 32'd1) : sy;
        mag_u = r_in.vel_u[31] ? (~r_in.vel_u + 32'd1) : r_in.vel_u;
        mag_v = r_in.vel_v[31] ? (~r_in.vel_v + 32'd1) : r_in.vel_v;
    end

    // The one shared multiplier; its operands follow the operation.
    logic [31:0] mul_a, mul_b;

    always_comb begin
        case (i_cmd.op)
            OP_M1:   begin mul_a = mag_u;            mul_b = r_mx;   end
            OP_M2:   begin mul_a = mag_v;            mul_b = r_my;   end
            OP_M3:   begin mul_a = r_mx;             mul_b = r_mx;   end
            OP_M4:   begin mul_a = r_my;             mul_b = r_my;   end
            OP_M6:   begin mul_a = {1'b0, r_in.sound_speed}; mul_b = r_root; end
            OP_M8:   begin mul_a = {12'd0, r_cfl};   mul_b = {1'b0, r_in.cell_area}; end
            default: begin mul_a = '0;               mul_b = '0;     end
        endcase
    end

    // Sign-magnitude dot product of the two partial products.
    logic        neg1, neg2;
    logic [63:0] dot_val;

    always_comb begin
        neg1 = r_in.vel_u[31] ^ r_nx;
        neg2 = r_in.vel_v[31] ^ r_ny;
        if (neg1 == neg2) begin
            dot_val = r_p1 + r_prod;
        end else if (r_p1 > r_prod) begin
            dot_val = r_p1 - r_prod;
        end else begin
            dot_val = r_prod - r_p1;
        end
    end

    // One root bit per step.
    logic [REM_W-1:0] rem_sh, trial;
    logic             root_bit;

    always_comb begin
        rem_sh   = {r_rem[REM_W-3:0], r_rad[63:62]};
        trial    = {1'b0, r_root, 2'b01};
        root_bit = (rem_sh >= trial);
    end

    // Spectral radius of the face just finished.
    logic [63:0]     rad_sum;
    logic [SR_W-1:0] sr;

    always_comb begin
        rad_sum = r_dot + r_prod;
        sr      = rad_sum[63:FRAC_BITS];
    end

    // One quotient bit per step.
    logic [DEN_W:0] drem_sh;
    logic           q_bit;

    always_comb begin
        drem_sh = {r_drem, r_num[NUM_W-1]};
        q_bit   = (drem_sh >= {1'b0, r_den});
    end

    // Step of the cell, its check, and the end of pass.
    logic [31:0]        dt;
    logic               bad;
    logic [20:0]        cnt_next;
    logic [20:0]        cnt_eff;
    logic [LIMIT_W-1:0] limit;

    always_comb begin
        if (r_den == '0) begin
            dt = '1;
        end else if (r_num[NUM_W-1:32] != '0) begin
            dt = '1;
        end else begin
            dt = r_num[31:0];
        end
        bad      = r_zero || r_numz || (dt == '0);
        cnt_next = r_counter + 21'd1;
        cnt_eff  = (r_cell_count == '0) ? 21'd1 : r_cell_count;
        if (LIMIT_W'(cnt_eff) > LIMIT_W'(MAX_CELLS)) begin
            limit = LIMIT_W'(MAX_CELLS);
        end else begin
            limit = LIMIT_W'(cnt_eff);
        end
        o_sts.pass_end = (LIMIT_W'(cnt_next) >= limit) || (cnt_next == '0);
        o_sts.out_busy = r_out_valid && !i_out_ready;
    end

    // Datapath registers under control of the sequencer.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (i_cmd.op)
            OP_LOAD: r_in <= i_cell;
            OP_FACE: begin
                r_mx <= mag_x;
                r_my <= mag_y;
                r_nx <= sx[31];
                r_ny <= sy[31];
            end
            OP_M2: r_p1  <= r_prod;
            OP_M3: r_dot <= dot_val;
            OP_M4: r_rad <= r_prod;
            OP_M5: begin
                r_rad  <= r_rad + r_prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQRT: begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= root_bit ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[30:0], root_bit};
            end
            OP_M7: begin
                if (i_cmd.face) begin
                    r_den  <= r_den + DEN_W'(sr);
                    r_zero <= r_zero || (r_root == '0);
                end else begin
                    r_den  <= DEN_W'(sr);
                    r_zero <= (r_root == '0);
                end
            end
            OP_M9: begin
                r_num  <= r_prod[NUM_W-1:0];
                r_numz <= (r_prod == '0);
                r_drem <= '0;
            end
            OP_DIV: begin
                r_drem <= q_bit ? DEN_W'(drem_sh - {1'b0, r_den}) : DEN_W'(drem_sh);
                r_num  <= {r_num[NUM_W-2:0], q_bit};
            end
            default: ;
        endcase
    end

    // Running minimum, error capture and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min       <= '1;
            r_counter   <= '0;
            r_err       <= 1'b0;
            r_first_bad <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The result register fills at a pass end and empties on a transfer.
            if (i_cmd.op == OP_FINISH && o_sts.pass_end) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_FINISH) begin
                if (o_sts.pass_end) begin
                    r_out.min_step <= (!bad && dt < r_min) ? dt : r_min;
                    r_out.bad_step <= r_err || bad;
                    r_out.bad_cell <= r_err ? r_first_bad : (bad ? r_counter[19:0] : '0);
                    r_min          <= '1;
                    r_counter      <= '0;
                    r_err          <= 1'b0;
                    r_first_bad    <= '0;
                end else begin
                    r_counter <= cnt_next;
                    if (bad) begin
                        if (!r_err) begin
                            r_err       <= 1'b1;
                            r_first_bad <= r_counter[19:0];
                        end
                    end else if (dt < r_min) begin
                        r_min <= dt;
                    end
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A fresh pass carries no leftovers.
    a_fresh_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_counter == '0) |-> (r_min == '1 && !r_err && r_first_bad == '0))
        else $error("pass state not cleared at start of pass");

    a_first_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_err |-> (r_first_bad == '0))
        else $error("first bad cell recorded without error");

    a_out_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.bad_step) |-> (r_out.bad_cell == '0))
        else $error("bad cell index reported without error");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH && o_sts.pass_end) |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

endmodule

FILE: design/cfl_global_time_step.sv
// CFL global time step unit. Each input transfer is one grid cell; the unit
// forms that cell's step cfl*area/(sum of spectral radii) in fixed point and
// keeps the minimum over a pass of cell_count cells, then gives one result
// with the minimum step and a sticky bad-cell flag and index. A cell runs
// to the end before the next cell can be taken: two face passes, each
// dominated by a 32-step serial square root, and a 51-step serial divider,
// on top of one shared multiplier and a sequencer. The result waits in an
// output register, so the next cell may enter while it is still not taken;
// a cell that ends the following pass holds in its last cycle until that
// earlier result is taken. Configuration writes are always accepted and
// must only be made while no cell is in progress.
module cfl_global_time_step #(
    parameter int FRAC_BITS = cts_pkg::FRAC_BITS_DEF,
    parameter int MAX_CELLS = cts_pkg::MAX_CELLS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cts_stream_if.sink   i_cell,
    cts_stream_if.source o_step,
    cts_stream_if.sink   i_cfg
);
    import cts_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_cell.ready = in_ready;
    assign i_cfg.ready  = 1'b1;

    cts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cts_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_CELLS (MAX_CELLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cell      (i_cell.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .o_out_valid (o_step.valid),
        .i_out_ready (o_step.ready),
        .o_out       (o_step.data)
    );

endmodule
